>>> rtl/sur_pkg.sv
// ----------------------------------------------------------------------------
// sur_pkg
// Shared types, widths and saturating arithmetic of the sum-up rounding
// row selector.
// ----------------------------------------------------------------------------
`default_nettype none

package sur_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int FRAC_BITS = 16;

  localparam int VALUE_W  = FRAC_BITS + 1;
  localparam int CARRY_W  = FRAC_BITS + 3;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int CHOSEN_W = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [CARRY_W-1:0] carry_t;
  typedef logic signed [CARRY_W:0]   wide_t;

  localparam wide_t WIDE_MAX  = wide_t'((64'sd1 <<< (CARRY_W - 1)) - 64'sd1);
  localparam wide_t WIDE_MIN  = wide_t'(-(64'sd1 <<< (CARRY_W - 1)));
  localparam wide_t ONE_WIDE  = wide_t'(64'sd1 <<< FRAC_BITS);

  typedef struct packed {
    logic [VALUE_W-1:0] relaxed_value;
    logic               first_column;
    logic               last_row;
  } in_item_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen_row;
    logic                no_eligible_row;
  } out_item_t;

  // classified row request, front to back
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row;
    logic               skip;
    logic               first;
    logic               last;
    logic               may_win;
  } row_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  function automatic carry_t sat_wide(input wide_t v);
    if (v > WIDE_MAX) begin
      return carry_t'(WIDE_MAX);
    end else if (v < WIDE_MIN) begin
      return carry_t'(WIDE_MIN);
    end
    return carry_t'(v);
  endfunction

  function automatic carry_t sat_add_value(input carry_t c, input logic [VALUE_W-1:0] v);
    return sat_wide(wide_t'(c) + wide_t'({1'b0, v}));
  endfunction

  function automatic carry_t sat_minus_one(input carry_t c);
    return sat_wide(wide_t'(c) - ONE_WIDE);
  endfunction

endpackage

`default_nettype wire

>>> rtl/sur_front.sv
// ----------------------------------------------------------------------------
// sur_front
// Accepts row requests, tracks the row position within the column and
// classifies each request before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sur_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire                    cfg_data,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  sur_pkg::in_item_t      in_item,
  input  sur_pkg::queue_status_t q_status,
  output logic                   push,
  output sur_pkg::row_item_t     push_item
);
  import sur_pkg::*;

  logic             eligible_only_mode;
  logic [CNT_W-1:0] row_count;
  logic             at_limit;

  assign at_limit = (row_count == CNT_W'(MAX_ROWS));
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.value   = in_item.relaxed_value;
    push_item.row     = row_count[ROW_W-1:0];
    push_item.skip    = at_limit;
    push_item.first   = in_item.first_column;
    push_item.last    = in_item.last_row;
    push_item.may_win = !eligible_only_mode || (in_item.relaxed_value != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eligible_only_mode <= 1'b0;
      row_count          <= '0;
    end else begin
      if (cfg_we) begin
        eligible_only_mode <= cfg_data;
      end
      if (push) begin
        if (in_item.last_row) begin
          row_count <= '0;
        end else if (!at_limit) begin
          // rows past the limit are marked skip, counter holds
          row_count <= row_count + CNT_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sur_queue.sv
// ----------------------------------------------------------------------------
// sur_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module sur_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  sur_pkg::row_item_t     push_item,
  input  wire                    pop,
  output sur_pkg::row_item_t     pop_item,
  output sur_pkg::queue_status_t status
);
  import sur_pkg::*;

  row_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sur_back.sv
// ----------------------------------------------------------------------------
// sur_back
// Carry update and running maximum per row, decision and result register
// at the end of each column.
// ----------------------------------------------------------------------------
`default_nettype none

module sur_back (
  input  wire                    clk,
  input  wire                    rst,
  input  sur_pkg::queue_status_t q_status,
  input  sur_pkg::row_item_t     pop_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output sur_pkg::out_item_t     out_item
);
  import sur_pkg::*;

  carry_t              row_carry [MAX_ROWS];
  // chosen row still owes its minus one, applied when it is next read
  logic [MAX_ROWS-1:0] row_owes;
  logic [MAX_ROWS-1:0] row_owes_next;
  carry_t              best_value;
  logic [ROW_W-1:0]    best_row;
  logic                best_found;

  carry_t              stored;
  carry_t              carry_in;
  carry_t              acc;
  logic                take;
  carry_t              best_value_next;
  logic [ROW_W-1:0]    best_row_next;
  logic                best_found_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;
  assign pop      = !q_status.empty && (!pop_item.last || out_free);

  always_comb begin
    stored   = row_owes[pop_item.row] ? sat_minus_one(row_carry[pop_item.row])
                                      : row_carry[pop_item.row];
    carry_in = pop_item.first ? carry_t'(0) : stored;
    acc      = sat_add_value(carry_in, pop_item.value);
    take     = !pop_item.skip && pop_item.may_win && (!best_found || (acc > best_value));
    best_found_next = best_found || take;
    best_row_next   = take ? pop_item.row : best_row;
    best_value_next = take ? acc : best_value;
  end

  // a row that is read settles its debt, the new winner takes one on
  always_comb begin
    row_owes_next = row_owes;
    if (pop && !pop_item.skip) begin
      row_owes_next[pop_item.row] = 1'b0;
    end
    if (pop && pop_item.last && best_found_next) begin
      row_owes_next[best_row_next] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        row_carry[i] <= '0;
      end
      row_owes   <= '0;
      best_value <= '0;
      best_row   <= '0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
      out_item   <= '0;
    end else begin
      row_owes <= row_owes_next;
      if (pop && pop_item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (!pop_item.skip) begin
          row_carry[pop_item.row] <= acc;
        end
        if (pop_item.last) begin
          out_item.chosen_row      <= best_found_next ? CHOSEN_W'(best_row_next) : '0;
          out_item.no_eligible_row <= !best_found_next;
          best_value <= '0;
          best_row   <= '0;
          best_found <= 1'b0;
        end else begin
          best_value <= best_value_next;
          best_row   <= best_row_next;
          best_found <= best_found_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sum_up_rounding_selector.sv
// ----------------------------------------------------------------------------
// sum_up_rounding_selector
// Sum-up rounding row selector: one row value per request, one decision
// per column, front classifier and back update joined by a short queue.
// ----------------------------------------------------------------------------
// throughput: one row request per cycle, sustained while the result register does not stall,
//   with the carry read, add and compare done combinationally in the back part
// result path: an accepted last-row request passes the queue slot, then the
//   result register, and waits in the queue while the result register is stalled
// reset: synchronous; clears carries, row counter, running best, queue
//   and mode register at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module sum_up_rounding_selector (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire                cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  sur_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  wire                out_ready,
  output sur_pkg::out_item_t out_item
);
  import sur_pkg::*;

  logic          q_push;
  logic          q_pop;
  row_item_t     q_push_item;
  row_item_t     q_pop_item;
  queue_status_t q_status;

  sur_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_status  (q_status),
    .push      (q_push),
    .push_item (q_push_item)
  );

  sur_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .status    (q_status)
  );

  sur_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_item  (q_pop_item),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("back popped an empty queue");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !q_status.empty)
    else $error("accepted request missing from queue");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_pop_item.last) |=> out_valid)
    else $error("column end gave no result");

endmodule

`default_nettype wire
